/* design/tacc_pkg.sv */
// Shared opcodes, phase codes and cycle charges for the tiny accumulator core.
package tacc_pkg;

  localparam int AddrWidth  = 16;
  localparam int DataWidth  = 8;
  localparam int CountWidth = 32;
  localparam int PhaseWidth = 3;
  localparam int CostWidth  = 3;

  typedef logic [AddrWidth-1:0]  addr_t;
  typedef logic [DataWidth-1:0]  byte_t;
  typedef logic [CountWidth-1:0] count_t;
  typedef logic [PhaseWidth-1:0] phase_t;
  typedef logic [CostWidth-1:0]  cost_t;

  localparam phase_t PH_FETCH   = 3'd0;
  localparam phase_t PH_IMM     = 3'd1;
  localparam phase_t PH_ADDR_LO = 3'd2;
  localparam phase_t PH_ADDR_HI = 3'd3;
  localparam phase_t PH_WRITE   = 3'd4;
  localparam phase_t PH_READ    = 3'd5;

  localparam byte_t OP_NOP      = 8'h00;
  localparam byte_t OP_LOAD_IMM = 8'h01;
  localparam byte_t OP_JUMP     = 8'h02;
  localparam byte_t OP_STORE    = 8'h10;
  localparam byte_t OP_LOAD_MEM = 8'h11;
  localparam byte_t OP_ADD      = 8'h20;
  localparam byte_t OP_BRK      = 8'h30;

  localparam cost_t COST_IDLE  = 3'd1;
  localparam cost_t COST_SHORT = 3'd2;
  localparam cost_t COST_JMP   = 3'd3;
  localparam cost_t COST_MEM   = 3'd4;

endpackage

/* design/tiny_accumulator_cpu_core.sv */
// Tiny accumulator CPU core: bus-response in, next bus request and state out.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------------
//   in       | in_valid / in_stall     | read_data
//   out      | out_valid / out_stall   | bus_address ... cycle_total
//   cfg      | cfg_valid / cfg_ready   | cfg_data (reset_pc)
//
// One request per cycle while in_stall is low: each accepted response is decoded and the next
// architectural state and bus request are registered in the same cycle.
// The result register frees up whenever it is taken, so a new request is
// accepted while the previous result is leaving. Synchronous reset clears all
// control state and the PC; a cfg write before the first request moves the
// first fetch, later ones have no effect. in_stall is high only while a
// result is held.
module tiny_accumulator_cpu_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  tacc_pkg::addr_t cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  tacc_pkg::byte_t read_data,
  output logic            out_valid,
  input  logic            out_stall,
  output tacc_pkg::addr_t bus_address,
  output logic            bus_write,
  output tacc_pkg::byte_t bus_write_data,
  output logic            bus_active,
  output tacc_pkg::byte_t accumulator,
  output tacc_pkg::addr_t program_counter,
  output logic            halt_flag,
  output logic            instruction_done,
  output tacc_pkg::count_t cycle_total
);
  import tacc_pkg::*;

  addr_t  pc, pc_next;
  byte_t  acc, acc_next;
  logic   halted, halted_next;
  phase_t phase, phase_next;
  byte_t  opcode, opcode_next;
  byte_t  operand_low, operand_low_next;
  addr_t  target_address, target_address_next;
  count_t cycle_counter, cycle_counter_next;
  logic   fresh;
  logic   done_next;
  cost_t  cost;
  addr_t  pc_inc;
  logic   accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign pc_inc    = pc + addr_t'(1);

  always_comb begin
    pc_next             = pc;
    acc_next            = acc;
    halted_next         = halted;
    phase_next          = phase;
    opcode_next         = opcode;
    operand_low_next    = operand_low;
    target_address_next = target_address;
    done_next           = 1'b0;
    cost                = '0;
    if (halted) begin
      cost      = COST_IDLE;
      done_next = 1'b1;
    end else begin
      case (phase)
        PH_FETCH: begin
          opcode_next = read_data;
          pc_next     = pc_inc;
          case (read_data)
            OP_LOAD_IMM, OP_ADD: phase_next = PH_IMM;
            OP_JUMP, OP_STORE, OP_LOAD_MEM: phase_next = PH_ADDR_LO;
            OP_BRK: begin
              halted_next = 1'b1;
              cost        = COST_SHORT;
              done_next   = 1'b1;
            end
            default: begin
              // NOP and any unknown opcode
              cost      = COST_SHORT;
              done_next = 1'b1;
            end
          endcase
        end
        PH_IMM: begin
          pc_next    = pc_inc;
          acc_next   = (opcode == OP_ADD) ? acc + read_data : read_data;
          cost       = COST_SHORT;
          done_next  = 1'b1;
          phase_next = PH_FETCH;
        end
        PH_ADDR_LO: begin
          operand_low_next = read_data;
          pc_next          = pc_inc;
          phase_next       = PH_ADDR_HI;
        end
        PH_ADDR_HI: begin
          target_address_next = {read_data, operand_low};
          if (opcode == OP_JUMP) begin
            pc_next    = {read_data, operand_low};
            cost       = COST_JMP;
            done_next  = 1'b1;
            phase_next = PH_FETCH;
          end else begin
            pc_next    = pc_inc;
            phase_next = (opcode == OP_STORE) ? PH_WRITE : PH_READ;
          end
        end
        PH_WRITE: begin
          cost       = COST_MEM;
          done_next  = 1'b1;
          phase_next = PH_FETCH;
        end
        PH_READ: begin
          acc_next   = read_data;
          cost       = COST_MEM;
          done_next  = 1'b1;
          phase_next = PH_FETCH;
        end
        default: phase_next = PH_FETCH;
      endcase
    end
    cycle_counter_next = cycle_counter + count_t'(cost);
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc             <= '0;
      acc            <= '0;
      halted         <= 1'b0;
      phase          <= PH_FETCH;
      opcode         <= '0;
      operand_low    <= '0;
      target_address <= '0;
      cycle_counter  <= '0;
      fresh          <= 1'b1;
    end else begin
      if (accept) begin
        pc             <= pc_next;
        acc            <= acc_next;
        halted         <= halted_next;
        phase          <= phase_next;
        opcode         <= opcode_next;
        operand_low    <= operand_low_next;
        target_address <= target_address_next;
        cycle_counter  <= cycle_counter_next;
        fresh          <= 1'b0;
      end else if (cfg_valid && cfg_ready && fresh) begin
        // reset_pc written before the first request also moves the fetch
        pc <= cfg_data;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bus_active       <= ~halted_next;
      bus_write        <= ~halted_next & (phase_next == PH_WRITE);
      bus_write_data   <= (~halted_next & (phase_next == PH_WRITE)) ? acc_next : '0;
      if (halted_next) begin
        bus_address <= '0;
      end else if (phase_next == PH_WRITE || phase_next == PH_READ) begin
        bus_address <= target_address_next;
      end else begin
        bus_address <= pc_next;
      end
      accumulator      <= acc_next;
      program_counter  <= pc_next;
      halt_flag        <= halted_next;
      instruction_done <= done_next;
      cycle_total      <= cycle_counter_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && halt_flag |-> !bus_active && !bus_write)
    else $error("halted core still requests the bus");

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    accept && halted |=> halted && cycle_counter == $past(cycle_counter) + count_t'(1))
    else $error("idle tick did not charge exactly one cycle");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && bus_write |-> phase == PH_WRITE && bus_address == target_address)
    else $error("write request outside the store phase");

  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(phase) && $stable(acc) && $stable(cycle_counter))
    else $error("state moved without a request");
`endif

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the tiny accumulator core: predicts each bus request and checks it.
module tb_top;
  import tacc_pkg::*;

  typedef struct {
    addr_t  bus_address;
    logic   bus_write;
    byte_t  bus_write_data;
    logic   bus_active;
    byte_t  accumulator;
    addr_t  program_counter;
    logic   halt_flag;
    logic   instruction_done;
    count_t cycle_total;
  } core_view_t;

  logic   clk;
  logic   rst;
  logic   cfg_valid;
  logic   cfg_ready;
  addr_t  cfg_data;
  logic   in_valid;
  logic   in_stall;
  byte_t  read_data;
  logic   out_valid;
  logic   out_stall;
  addr_t  bus_address;
  logic   bus_write;
  byte_t  bus_write_data;
  logic   bus_active;
  byte_t  accumulator;
  addr_t  program_counter;
  logic   halt_flag;
  logic   instruction_done;
  count_t cycle_total;

  tiny_accumulator_cpu_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .read_data        (read_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .bus_address      (bus_address),
    .bus_write        (bus_write),
    .bus_write_data   (bus_write_data),
    .bus_active       (bus_active),
    .accumulator      (accumulator),
    .program_counter  (program_counter),
    .halt_flag        (halt_flag),
    .instruction_done (instruction_done),
    .cycle_total      (cycle_total)
  );

  always #2 clk = ~clk;

  // Core state as the checker believes it to be
  addr_t  m_pc;
  addr_t  m_target;
  byte_t  m_acc;
  byte_t  m_opcode;
  byte_t  m_addr_lo;
  logic   m_halted;
  logic   m_fresh;
  phase_t m_phase;
  count_t m_cycles;

  core_view_t predicted_states[$];
  int         mismatches;
  int         send_idle_pct;
  int         recv_stall_pct;

  function automatic void retire(input cost_t c);
    m_cycles = m_cycles + count_t'(c);
    m_phase  = PH_FETCH;
  endfunction

  function automatic core_view_t advance_core(input byte_t d);
    core_view_t v;
    logic       done;
    done    = 1'b0;
    m_fresh = 1'b0;
    if (m_halted) begin
      m_cycles = m_cycles + count_t'(COST_IDLE);
      done     = 1'b1;
    end else begin
      case (m_phase)
        PH_FETCH: begin
          m_opcode = d;
          m_pc     = m_pc + 16'd1;
          case (d)
            OP_LOAD_IMM, OP_ADD: m_phase = PH_IMM;
            OP_JUMP, OP_STORE, OP_LOAD_MEM: m_phase = PH_ADDR_LO;
            OP_BRK: begin
              m_halted = 1'b1;
              retire(COST_SHORT);
              done = 1'b1;
            end
            default: begin
              // NOP and any undefined opcode
              retire(COST_SHORT);
              done = 1'b1;
            end
          endcase
        end
        PH_IMM: begin
          m_pc  = m_pc + 16'd1;
          m_acc = (m_opcode == OP_ADD) ? byte_t'(m_acc + d) : d;
          retire(COST_SHORT);
          done = 1'b1;
        end
        PH_ADDR_LO: begin
          m_addr_lo = d;
          m_pc      = m_pc + 16'd1;
          m_phase   = PH_ADDR_HI;
        end
        PH_ADDR_HI: begin
          m_target = {d, m_addr_lo};
          m_pc     = m_pc + 16'd1;
          if (m_opcode == OP_JUMP) begin
            m_pc = m_target;
            retire(COST_JMP);
            done = 1'b1;
          end else if (m_opcode == OP_STORE) begin
            m_phase = PH_WRITE;
          end else begin
            m_phase = PH_READ;
          end
        end
        PH_WRITE: begin
          // write ack, data ignored
          retire(COST_MEM);
          done = 1'b1;
        end
        PH_READ: begin
          m_acc = d;
          retire(COST_MEM);
          done = 1'b1;
        end
        default: m_phase = PH_FETCH;
      endcase
    end

    v.bus_address    = '0;
    v.bus_write      = 1'b0;
    v.bus_write_data = '0;
    v.bus_active     = 1'b0;
    if (!m_halted) begin
      v.bus_active = 1'b1;
      if (m_phase == PH_WRITE) begin
        v.bus_address    = m_target;
        v.bus_write      = 1'b1;
        v.bus_write_data = m_acc;
      end else if (m_phase == PH_READ) begin
        v.bus_address = m_target;
      end else begin
        v.bus_address = m_pc;
      end
    end
    v.accumulator      = m_acc;
    v.program_counter  = m_pc;
    v.halt_flag        = m_halted;
    v.instruction_done = done;
    v.cycle_total      = m_cycles;
    return v;
  endfunction

  // Memory side: opcodes when the core fetches, random bytes otherwise. Never BRK here.
  function automatic byte_t next_response();
    byte_t b;
    if (m_halted || m_phase != PH_FETCH) return byte_t'($urandom_range(255));
    if ($urandom_range(99) < 12) begin
      b = byte_t'($urandom_range(255));
      return (b == OP_BRK) ? OP_NOP : b;
    end
    case ($urandom_range(5))
      0:       return OP_NOP;
      1:       return OP_LOAD_IMM;
      2:       return OP_JUMP;
      3:       return OP_STORE;
      4:       return OP_LOAD_MEM;
      default: return OP_ADD;
    endcase
  endfunction

  task automatic drive_response(input byte_t d);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    read_data <= d;
    do @(posedge clk); while (in_stall);
    predicted_states.push_back(advance_core(d));
  endtask

  task automatic write_reset_pc(input addr_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    // only loads the PC before the first request
    if (m_fresh) m_pc = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic await_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_states.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    core_view_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_states.size() == 0) begin
        $error("unexpected result: bus_address %0h", bus_address);
        mismatches++;
      end else begin
        want = predicted_states.pop_front();
        check_field("bus_address", 32'(want.bus_address), 32'(bus_address));
        check_field("bus_write", 32'(want.bus_write), 32'(bus_write));
        check_field("bus_write_data", 32'(want.bus_write_data), 32'(bus_write_data));
        check_field("bus_active", 32'(want.bus_active), 32'(bus_active));
        check_field("accumulator", 32'(want.accumulator), 32'(accumulator));
        check_field("program_counter", 32'(want.program_counter), 32'(program_counter));
        check_field("halt_flag", 32'(want.halt_flag), 32'(halt_flag));
        check_field("instruction_done", 32'(want.instruction_done),
                    32'(instruction_done));
        check_field("cycle_total", want.cycle_total, cycle_total);
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Several writes before the first request; the last one starts fetching just below the wrap.
  task automatic test_reset_pc_load();
    write_reset_pc(16'h1234);
    write_reset_pc(16'h0000);
    write_reset_pc(16'hFFFE);
  endtask

  task automatic test_directed();
    byte_t prog[$];
    prog = '{OP_NOP, OP_LOAD_IMM, 8'hFF, OP_ADD, 8'h01, OP_ADD, 8'hFF,
             OP_STORE, 8'hFF, 8'hFF, 8'hA5, OP_LOAD_MEM, 8'h00, 8'h00, 8'h80,
             OP_JUMP, 8'hFF, 8'hFF, 8'hFF, 8'h03};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (prog[i]) drive_response(prog[i]);
    await_results();
  endtask

  // Once running, reset_pc writes must leave the PC alone
  task automatic test_late_reset_pc_writes();
    write_reset_pc(16'hFFFF);
    write_reset_pc(16'h0000);
    drive_response(next_response());
    await_results();
  endtask

  task automatic test_random(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(59) == 0) await_results();
      drive_response(next_response());
    end
    await_results();
    write_reset_pc(addr_t'($urandom_range(16'hFFFF)));
  endtask

  task automatic test_halt();
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    while (m_phase != PH_FETCH) drive_response(next_response());
    drive_response(OP_BRK);
    repeat (30) drive_response(byte_t'($urandom_range(255)));
    await_results();
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    read_data      = '0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    m_pc           = '0;
    m_target       = '0;
    m_acc          = '0;
    m_opcode       = '0;
    m_addr_lo      = '0;
    m_halted       = 1'b0;
    m_fresh        = 1'b1;
    m_phase        = PH_FETCH;
    m_cycles       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_pc_load();
    test_directed();
    test_late_reset_pc_writes();
    test_random(0, 0, 240);
    test_random(47, 0, 230);
    test_random(0, 47, 230);
    test_random(8, 8, 230);
    test_halt();

    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
design/tacc_pkg.sv
design/tiny_accumulator_cpu_core.sv
tb/sv/tb_top.sv
